// ===== sv/line_sensor_pd_steering_defines.svh =====
// Assertion macros for the line sensor PD steering block.
// No dependencies; included by the files that carry assertions.
`ifndef LINE_SENSOR_PD_STEERING_DEFINES_SVH
`define LINE_SENSOR_PD_STEERING_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define LSPS_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define LSPS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsps_pkg.sv =====
// Types and constants shared by the line sensor PD steering modules.
// No dependencies.
package lsps_pkg;

  // Line error in tenths, signed
  typedef logic signed [5:0] error_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_KP_GAIN    = 2'd0;
  localparam logic [1:0] CFG_KD_GAIN    = 2'd1;
  localparam logic [1:0] CFG_BASE_SPEED = 2'd2;

  // Register reset values
  localparam logic [11:0] KP_GAIN_RESET    = 12'd1050;
  localparam logic [9:0]  KD_GAIN_RESET    = 10'd75;
  localparam logic [11:0] BASE_SPEED_RESET = 12'd1100;

  // Magnitude of a wheel value in tenths stays below 2**18
  localparam int MAG_W = 18;
  // Reciprocal of ten: ceil(2**21 / 10), exact for magnitudes below 2**18
  localparam int DIV10_SHIFT = 21;
  localparam logic [MAG_W-1:0] DIV10_MUL = 18'd209716;
  localparam int PROD_W = 2 * MAG_W;

endpackage

// ===== sv/lsps_decoder.sv =====
// Priority decoder from the 9 sensor bits to a line error in tenths.
// Depends on lsps_pkg.
module lsps_decoder (
  input  logic [8:0]      sensor_bits,
  input  lsps_pkg::error_t last_error,
  output lsps_pkg::error_t line_error
);
  import lsps_pkg::*;

  logic [8:0] edge_bits;

  assign edge_bits = sensor_bits & 9'h183;

  // Center patterns first, then the outer sensors; hold the last error on no match
  always_comb begin
    case (sensor_bits)
      9'h038:  line_error = 6'sd0;
      9'h078:  line_error = 6'sd3;
      9'h03C:  line_error = -6'sd3;
      9'h070:  line_error = 6'sd5;
      9'h01C:  line_error = -6'sd5;
      9'h060:  line_error = 6'sd8;
      9'h00C:  line_error = -6'sd8;
      default: begin
        case (edge_bits)
          9'h002:  line_error = -6'sd14;
          9'h003:  line_error = -6'sd25;
          9'h080:  line_error = 6'sd15;
          9'h180:  line_error = 6'sd25;
          9'h000:  line_error = 6'sd0;
          default: line_error = last_error;
        endcase
      end
    endcase
  end

endmodule

// ===== sv/lsps_wheel.sv =====
// Divide a wheel value in tenths by ten, truncating toward zero.
// Depends on lsps_pkg for the reciprocal constant and widths.
module lsps_wheel (
  input  logic [lsps_pkg::MAG_W-1:0] mag,
  input  logic                       neg,
  output logic signed [15:0]         speed
);
  import lsps_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [15:0]       quot;

  // Multiply by the reciprocal; the magnitude is truncated, so sign goes on after
  assign prod = PROD_W'(mag) * PROD_W'(DIV10_MUL);
  assign quot = 16'(prod[PROD_W-1:DIV10_SHIFT]);

  // Quotient stays below 19448, so the 16-bit result never saturates
  assign speed = neg ? -$signed(quot) : $signed(quot);

endmodule

// ===== sv/line_sensor_pd_steering.sv =====
// Line sensor PD steering: takes one 9-bit sensor sample per clock unless stalled and
// returns four wheel speeds and the decoded line error through stages A, B and C.
// A sample may be transferred every cycle; the pipeline (decode and gain multiply,
// sum, divide by ten through a reciprocal multiply) moves as one, so a stalled
// result holds every stage and in_stall follows out_valid and out_stall.
// Write the gain and speed registers only while no sample is in flight.
// Depends on lsps_pkg, lsps_decoder, lsps_wheel and the assertion header.
`include "line_sensor_pd_steering_defines.svh"

module line_sensor_pd_steering (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration writes
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [11:0]             cfg_data,
  // Sensor samples
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [8:0]              sensor_bits,
  // Wheel speeds
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      wheel_one,
  output logic signed [15:0]      wheel_two,
  output logic signed [15:0]      wheel_three,
  output logic signed [15:0]      wheel_four,
  output lsps_pkg::error_t        line_error
);
  import lsps_pkg::*;

  logic        advance;

  // Configuration registers
  logic [11:0] kp_gain;
  logic [9:0]  kd_gain;
  logic [11:0] base_speed;

  // Decode state
  error_t      last_error;

  // Stage A: registered sample
  logic        a_valid;
  logic [8:0]  a_sensor;
  error_t      a_error_next;
  logic signed [6:0]  diff;
  logic signed [17:0] pterm_next;
  logic signed [16:0] dterm_next;

  // Stage B: gain products
  logic               b_valid;
  error_t             b_error;
  logic signed [17:0] b_pterm;
  logic signed [16:0] b_dterm;
  logic signed [18:0] sum;
  logic [15:0]        base_x10;
  logic signed [19:0] plus_val;
  logic signed [19:0] minus_val;
  logic signed [19:0] plus_abs;
  logic signed [19:0] minus_abs;

  // Stage C: wheel magnitudes in tenths
  logic             c_valid;
  error_t           c_error;
  logic [MAG_W-1:0] c_plus_mag;
  logic             c_plus_neg;
  logic [MAG_W-1:0] c_minus_mag;
  logic             c_minus_neg;
  logic signed [15:0] plus_speed;
  logic signed [15:0] minus_speed;

  // Whole pipeline moves unless a finished result is held
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Decode against the error left by the previous sample
  lsps_decoder u_decoder (
    .sensor_bits (a_sensor),
    .last_error  (last_error),
    .line_error  (a_error_next)
  );

  assign diff       = 7'(a_error_next) - 7'(last_error);
  assign pterm_next = $signed({6'b000000, kp_gain}) * 18'(a_error_next);
  assign dterm_next = $signed({7'b0000000, kd_gain}) * 17'(diff);

  // Form base*10 +/- the PD numerator and split into sign and magnitude
  assign sum       = 19'(b_pterm) + 19'(b_dterm);
  assign base_x10  = 16'({base_speed, 3'b000}) + 16'({base_speed, 1'b0});
  assign plus_val  = $signed({4'b0000, base_x10}) + 20'(sum);
  assign minus_val = $signed({4'b0000, base_x10}) - 20'(sum);
  assign plus_abs  = plus_val[19] ? -plus_val : plus_val;
  assign minus_abs = minus_val[19] ? -minus_val : minus_val;

  lsps_wheel u_wheel_plus (
    .mag   (c_plus_mag),
    .neg   (c_plus_neg),
    .speed (plus_speed)
  );

  lsps_wheel u_wheel_minus (
    .mag   (c_minus_mag),
    .neg   (c_minus_neg),
    .speed (minus_speed)
  );

  // Control state: configuration, stage valids and the held error
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain    <= KP_GAIN_RESET;
      kd_gain    <= KD_GAIN_RESET;
      base_speed <= BASE_SPEED_RESET;
      last_error <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_KP_GAIN:    kp_gain    <= cfg_data;
          CFG_KD_GAIN:    kd_gain    <= cfg_data[9:0];
          CFG_BASE_SPEED: base_speed <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        a_valid   <= in_valid;
        b_valid   <= a_valid;
        c_valid   <= b_valid;
        out_valid <= c_valid;
        if (a_valid) begin
          last_error <= a_error_next;
        end
      end
    end
  end

  // Payload: advance all stages together
  always_ff @(posedge clk) begin
    if (advance) begin
      a_sensor    <= sensor_bits;
      b_error     <= a_error_next;
      b_pterm     <= pterm_next;
      b_dterm     <= dterm_next;
      c_error     <= b_error;
      c_plus_mag  <= plus_abs[MAG_W-1:0];
      c_plus_neg  <= plus_val[19];
      c_minus_mag <= minus_abs[MAG_W-1:0];
      c_minus_neg <= minus_val[19];
      wheel_three <= plus_speed;
      wheel_one   <= -plus_speed;
      wheel_two   <= -minus_speed;
      wheel_four  <= -minus_speed;
      line_error  <= c_error;
    end
  end

  `LSPS_ASSERT_IMP(a_wheel_mirror, clk, rst, out_valid, (wheel_one + wheel_three) == 16'sd0, "wheel one is not the negation of wheel three")
  `LSPS_ASSERT_IMP(a_wheel_pair, clk, rst, out_valid, wheel_two == wheel_four, "wheels two and four differ")
  `LSPS_ASSERT_IMP(a_error_range, clk, rst, out_valid, (line_error >= -6'sd25) && (line_error <= 6'sd25), "line error out of range")
  `LSPS_ASSERT_NEXT(a_latency, clk, rst, (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid, "result missing four cycles after transfer")

endmodule

// ===== test/lsps_steering_checker.sv =====
`timescale 1ns / 100ps
// Checker for the line sensor PD steering block: watches register writes, sample and
// speed transfers, predicts each speed set and compares field by field. Uses lsps_pkg.
module lsps_steering_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [8:0]         sensor_bits,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] wheel_one,
  input  logic signed [15:0] wheel_two,
  input  logic signed [15:0] wheel_three,
  input  logic signed [15:0] wheel_four,
  input  lsps_pkg::error_t   line_error,
  output int                 mismatch_count,
  output int                 outstanding
);
  import lsps_pkg::*;

  typedef struct {
    logic signed [15:0] one;
    logic signed [15:0] two;
    logic signed [15:0] three;
    logic signed [15:0] four;
    error_t             err;
  } speed_set_t;

  logic [11:0] kp;
  logic [9:0]  kd;
  logic [11:0] base;
  error_t      held_error;
  speed_set_t  pending_speeds[$];
  int          errors = 0;

  assign mismatch_count = errors;

  // Map a sensor pattern to a line error; exact patterns first, then the edge sensors
  function automatic error_t decode_line(logic [8:0] s, error_t held);
    case (s)
      9'h038: return 6'sd0;
      9'h078: return 6'sd3;
      9'h03C: return -6'sd3;
      9'h070: return 6'sd5;
      9'h01C: return -6'sd5;
      9'h060: return 6'sd8;
      9'h00C: return -6'sd8;
      default: ;
    endcase
    case (s & 9'h183)
      9'h002: return -6'sd14;
      9'h003: return -6'sd25;
      9'h080: return 6'sd15;
      9'h180: return 6'sd25;
      9'h000: return 6'sd0;
      default: ;
    endcase
    // No pattern: hold the previous error
    return held;
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Work out the wheel speeds from values in tenths, truncated toward zero
  function automatic speed_set_t predict_speeds(logic [8:0] s, error_t prev);
    speed_set_t r;
    int e;
    int last;
    int sum;
    int b10;
    r.err = decode_line(s, prev);
    e     = int'(r.err);
    last  = int'(prev);
    sum   = int'(kp) * e + int'(kd) * (e - last);
    b10   = int'(base) * 10;
    r.one   = clamp16(-((b10 + sum) / 10));
    r.two   = clamp16(-((b10 - sum) / 10));
    r.three = clamp16((b10 + sum) / 10);
    r.four  = clamp16(-((b10 - sum) / 10));
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    speed_set_t want;
    if (rst) begin
      kp         = KP_GAIN_RESET;
      kd         = KD_GAIN_RESET;
      base       = BASE_SPEED_RESET;
      held_error = '0;
      pending_speeds.delete();
    end else begin
      // Track register writes; bits above each width and the spare index drop out
      if (cfg_write) begin
        case (cfg_index)
          CFG_KP_GAIN:    kp = cfg_data;
          CFG_KD_GAIN:    kd = cfg_data[9:0];
          CFG_BASE_SPEED: base = cfg_data;
          default: ;
        endcase
      end
      // Predict on each sample transfer
      if (in_valid && !in_stall) begin
        want       = predict_speeds(sensor_bits, held_error);
        held_error = want.err;
        pending_speeds.push_back(want);
      end
      // Compare each speed transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_speeds.size() == 0) begin
          report_mismatch("speed transfer with none pending", 1, 0);
        end else begin
          want = pending_speeds.pop_front();
          if (wheel_one !== want.one)
            report_mismatch("wheel_one", int'(wheel_one), int'(want.one));
          if (wheel_two !== want.two)
            report_mismatch("wheel_two", int'(wheel_two), int'(want.two));
          if (wheel_three !== want.three)
            report_mismatch("wheel_three", int'(wheel_three), int'(want.three));
          if (wheel_four !== want.four)
            report_mismatch("wheel_four", int'(wheel_four), int'(want.four));
          if (line_error !== want.err)
            report_mismatch("line_error", int'(line_error), int'(want.err));
        end
      end
    end
    outstanding <= pending_speeds.size();
  end

endmodule

// ===== test/tb_line_sensor_pd_steering.sv =====
`timescale 1ns / 100ps
// Testbench top for line_sensor_pd_steering: drives samples, register writes and
// output stalls, and gives the verdict. Uses lsps_pkg and lsps_steering_checker.
module tb_line_sensor_pd_steering;
  import lsps_pkg::*;

  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         TAIL_CYCLES  = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [8:0]         sensor_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] wheel_one;
  logic signed [15:0] wheel_two;
  logic signed [15:0] wheel_three;
  logic signed [15:0] wheel_four;
  error_t             line_error;

  int   mismatch_count;
  int   outstanding;
  int   cycle_count = 0;
  logic sender_idle = 1'b1;
  logic receiver_idle = 1'b1;
  logic hold_req = 1'b0;

  // Every decoder pattern, edge patterns with center bits, and patterns that hold
  logic [8:0] directed_samples [24] = '{
    9'h038, 9'h078, 9'h03C, 9'h070, 9'h01C, 9'h060, 9'h00C, 9'h002,
    9'h003, 9'h080, 9'h180, 9'h000, 9'h012, 9'h1FF, 9'h101, 9'h001,
    9'h100, 9'h082, 9'h07C, 9'h003, 9'h180, 9'h003, 9'h1BF, 9'h038
  };

  logic [8:0] exact_patterns [7] = '{
    9'h038, 9'h078, 9'h03C, 9'h070, 9'h01C, 9'h060, 9'h00C
  };
  logic [8:0] edge_patterns [5] = '{9'h002, 9'h003, 9'h080, 9'h180, 9'h000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_sensor_pd_steering dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sensor_bits(sensor_bits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .wheel_one  (wheel_one),
    .wheel_two  (wheel_two),
    .wheel_three(wheel_three),
    .wheel_four (wheel_four),
    .line_error (line_error)
  );

  lsps_steering_checker speed_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sensor_bits   (sensor_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .wheel_one     (wheel_one),
    .wheel_two     (wheel_two),
    .wheel_three   (wheel_three),
    .wheel_four    (wheel_four),
    .line_error    (line_error),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // Mostly short stretches, a few long ones
  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (!sender_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // Favor decodable patterns; keep some fully random noise
  function automatic logic [8:0] random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return exact_patterns[$urandom_range(0, 6)];
    if (pick < 70) return edge_patterns[$urandom_range(0, 4)] | (9'($urandom) & 9'h07C);
    return 9'($urandom);
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(logic [8:0] s);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sensor_bits <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Stop offering and wait until every predicted speed set has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, plus the spare index
  task automatic program_regs(logic [11:0] kp, logic [11:0] kd, logic [11:0] base);
    cfg_write <= 1'b1;
    cfg_index <= CFG_KP_GAIN;
    cfg_data  <= kp;
    @(posedge clk);
    cfg_index <= CFG_KD_GAIN;
    cfg_data  <= kd;
    @(posedge clk);
    cfg_index <= CFG_BASE_SPEED;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 12'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off on request, or none at all
  initial begin
    int len;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_idle) begin
        out_stall <= ($urandom_range(0, 2) == 0);
        len = idle_length();
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("line_sensor_pd_steering verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed patterns under reset gains
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    drain();

    // All gains and speed at zero, no idling on either side
    program_regs(12'd0, 12'd0, 12'd0);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_random(250);
    drain();

    // Everything at its top; hold off the receiver so the pipeline backs up
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    program_regs(12'd4095, 12'hFFF, 12'd4095);
    hold_req = 1'b1;
    send_random(250);
    drain();

    // Full proportional gain, no derivative, zero speed
    program_regs(12'd4095, 12'd0, 12'd0);
    send_random(250);
    drain();

    // Random settings, kd written with stray upper bits
    program_regs(12'($urandom), 12'($urandom), 12'($urandom));
    send_random(300);
    drain();

    program_regs(12'($urandom), 12'($urandom), 12'($urandom));
    sender_idle = 1'b0;
    send_random(300);
    drain();

    // Back to the reset gains
    sender_idle = 1'b1;
    program_regs(KP_GAIN_RESET, 12'(KD_GAIN_RESET), BASE_SPEED_RESET);
    send_random(275);
    drain();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("line_sensor_pd_steering verification clean");
    end else begin
      $display("line_sensor_pd_steering verification failed");
    end
    $finish;
  end

endmodule
